// File: design/redc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package redc_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int PLACE_W     = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0]  ADDR_SHUTDOWN = 4'hc;
    localparam logic [7:0]  CODE_BLANK    = 8'h0f;
    localparam logic [7:0]  DATA_OFF      = 8'd0;
    localparam logic [7:0]  DATA_ON       = 8'd1;
    localparam logic [15:0] TIMEOUT_RESET = 16'd610;
    localparam logic [15:0] IDLE_MAX      = 16'hffff;
    localparam logic [7:0]  RADIX         = 8'd10;
    // v / 10 == (v * 205) >> 11 for v < 1024
    localparam logic [15:0] RECIP_TEN     = 16'd205;
    localparam int          RECIP_SHIFT   = 11;

    typedef struct packed {
        logic mode;
        logic clk_level;
        logic dt_level;
    } t_in_item;

    typedef struct packed {
        logic [3:0] reg_address;
        logic [7:0] reg_data;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic       wake;
        logic       shut;
        logic       digits;
        logic [7:0] value;
    } t_cmd;

endpackage
`default_nettype wire

// File: design/redc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module redc_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire redc_pkg::t_in_item i_item,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output redc_pkg::t_cmd          o_cmd
);

    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_shown, n_shown;
    logic        r_clkp, n_clkp;
    logic        r_dtp, n_dtp;
    logic [15:0] r_idle, n_idle;
    logic        r_asleep, n_asleep;
    logic [15:0] r_timeout;
    redc_pkg::t_cmd s_cmd;
    logic        s_accept;

    assign o_ready  = !i_q_full;
    assign s_accept = i_valid && o_ready;
    assign o_cmd    = s_cmd;
    assign o_push   = s_accept && (s_cmd.wake || s_cmd.shut || s_cmd.digits);

    always_comb begin
        n_pos    = r_pos;
        n_shown  = r_shown;
        n_clkp   = r_clkp;
        n_dtp    = r_dtp;
        n_idle   = r_idle;
        n_asleep = r_asleep;
        s_cmd    = '0;
        if (i_item.mode) begin
            if (!r_asleep) begin
                n_idle = (r_idle == redc_pkg::IDLE_MAX) ? r_idle : r_idle + 16'd1;
                if (n_idle > r_timeout) begin
                    s_cmd.shut = 1'b1;
                    n_asleep   = 1'b1;
                end
            end
        end else begin
            n_dtp = i_item.dt_level;
            if (!r_asleep || (i_item.dt_level != r_dtp)) begin
                if (r_asleep) begin
                    s_cmd.wake = 1'b1;
                    n_idle     = '0;
                    n_asleep   = 1'b0;
                end
                if (r_clkp && !i_item.clk_level) begin
                    n_pos = i_item.dt_level ? r_pos - 8'd1 : r_pos + 8'd1;
                end
                n_clkp = i_item.clk_level;
                if (n_pos != r_shown) begin
                    n_shown      = n_pos;
                    n_idle       = '0;
                    s_cmd.digits = 1'b1;
                    s_cmd.value  = n_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_shown   <= '0;
            r_clkp    <= 1'b0;
            r_dtp     <= 1'b0;
            r_idle    <= '0;
            r_asleep  <= 1'b0;
            r_timeout <= redc_pkg::TIMEOUT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (s_accept) begin
                r_pos    <= n_pos;
                r_shown  <= n_shown;
                r_clkp   <= n_clkp;
                r_dtp    <= n_dtp;
                r_idle   <= n_idle;
                r_asleep <= n_asleep;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/redc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module redc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire redc_pkg::t_cmd i_cmd,
    output logic                o_full,
    output logic                o_valid,
    output redc_pkg::t_cmd      o_cmd,
    input  wire logic           i_pop
);

    redc_pkg::t_cmd r_mem [redc_pkg::QUEUE_DEPTH];
    logic [redc_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [redc_pkg::QCNT_W-1:0] r_cnt;
    logic s_push, s_pop;

    assign o_full  = (r_cnt == redc_pkg::QCNT_W'(redc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign s_push  = i_push && !o_full;
    assign s_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) begin
                r_wr <= r_wr + redc_pkg::QPTR_W'(1);
            end
            if (s_pop) begin
                r_rd <= r_rd + redc_pkg::QPTR_W'(1);
            end
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + redc_pkg::QCNT_W'(1);
            end else if (s_pop && !s_push) begin
                r_cnt <= r_cnt - redc_pkg::QCNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: design/redc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module redc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire redc_pkg::t_cmd i_q_cmd,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output redc_pkg::t_out_item o_item
);

    logic                         r_active;
    logic                         r_wake;
    logic                         r_shut;
    logic                         r_digits;
    logic [7:0]                   r_value;
    logic                         r_blank;
    logic [redc_pkg::PLACE_W-1:0] r_place;
    logic                         r_out_valid;
    redc_pkg::t_out_item          r_out;

    logic                s_slot;
    logic                s_emit;
    logic                s_done;
    logic                s_load;
    redc_pkg::t_out_item s_wr;
    logic [15:0]         s_prod;
    logic [7:0]          s_quot;
    logic [7:0]          s_rem;
    logic                s_digit_step;

    assign s_prod = 16'(r_value) * redc_pkg::RECIP_TEN;
    assign s_quot = 8'(s_prod >> redc_pkg::RECIP_SHIFT);
    assign s_rem  = r_value - 8'(s_quot * redc_pkg::RADIX);

    assign s_slot = !r_out_valid || i_ready;
    assign s_emit = r_active && s_slot;

    always_comb begin
        s_wr         = '0;
        s_digit_step = 1'b0;
        priority if (r_wake) begin
            s_wr.reg_address = redc_pkg::ADDR_SHUTDOWN;
            s_wr.reg_data    = redc_pkg::DATA_ON;
            s_wr.last_of_run = !r_digits;
        end else if (r_shut) begin
            s_wr.reg_address = redc_pkg::ADDR_SHUTDOWN;
            s_wr.reg_data    = redc_pkg::DATA_OFF;
            s_wr.last_of_run = 1'b1;
        end else begin
            s_digit_step     = 1'b1;
            s_wr.reg_address = 4'(r_place) + 4'd1;
            s_wr.reg_data    = r_blank ? redc_pkg::CODE_BLANK : s_rem;
            s_wr.last_of_run = (r_place == redc_pkg::PLACE_W'(redc_pkg::DIGIT_COUNT - 1));
        end
    end

    assign s_done = s_emit && s_wr.last_of_run;
    assign s_load = i_q_valid && (!r_active || s_done);
    assign o_pop  = s_load;

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_wake   <= i_q_cmd.wake;
            r_shut   <= i_q_cmd.shut;
            r_digits <= i_q_cmd.digits;
            r_value  <= i_q_cmd.value;
            r_blank  <= 1'b0;
            r_place  <= '0;
        end else if (s_emit) begin
            if (r_wake) begin
                r_wake <= 1'b0;
            end else if (s_digit_step) begin
                r_value <= s_quot;
                r_place <= r_place + redc_pkg::PLACE_W'(1);
                if (s_quot == '0) begin
                    r_blank <= 1'b1;
                end
            end
        end
        if (s_emit) begin
            r_out <= s_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_load) begin
                r_active <= 1'b1;
            end else if (s_done) begin
                r_active <= 1'b0;
            end
            if (s_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// File: design/rotary_encoder_display_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Rotary encoder position counter with display register writes.
// Input channel (i_valid/o_ready, i_item): one request per pin sample or
// timer tick; a request is taken every cycle while the command queue has room.
// Output channel (o_valid/i_ready, o_item): display register writes, one per
// request on that side; last_of_run marks the final write caused by an input.
// Configuration: i_cfg_we/i_cfg_data load the idle timeout.
// Each input's command passes through the queue, the back end's command
// registers and the output register; its later writes follow one per
// cycle unless stalled; an input makes 1 to DIGIT_COUNT + 1 writes or none.
// Sustained rate is set by the output side: the back end emits one write per
// cycle unless stalled; a queue of QUEUE_DEPTH commands absorbs front bursts.
// When the receiver stalls, the output register holds its write, the back end
// waits, the queue fills and then o_ready drops.
// Reset (synchronous, active low) clears position, idle counter, sleep state,
// queue and output; the timeout returns to 610 ticks.
module rotary_encoder_display_controller_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire redc_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output redc_pkg::t_out_item      o_item,
    input  wire logic                i_cfg_we,
    input  wire logic [15:0]         i_cfg_data
);

    logic           s_push;
    logic           s_full;
    redc_pkg::t_cmd s_push_cmd;
    logic           s_q_valid;
    redc_pkg::t_cmd s_q_cmd;
    logic           s_pop;

    redc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (s_full),
        .o_push     (s_push),
        .o_cmd      (s_push_cmd)
    );

    redc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_cmd   (s_push_cmd),
        .o_full  (s_full),
        .o_valid (s_q_valid),
        .o_cmd   (s_q_cmd),
        .i_pop   (s_pop)
    );

    redc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (s_q_valid),
        .i_q_cmd   (s_q_cmd),
        .o_pop     (s_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push |-> !s_full)
        else $error("command pushed into full queue");

    a_shutdown_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.reg_address == redc_pkg::ADDR_SHUTDOWN &&
         o_item.reg_data == redc_pkg::DATA_OFF) |-> o_item.last_of_run)
        else $error("display off write not last of run");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.reg_address != redc_pkg::ADDR_SHUTDOWN) |->
        (o_item.reg_address >= 4'd1 &&
         o_item.reg_address <= 4'(redc_pkg::DIGIT_COUNT) &&
         (o_item.reg_data < redc_pkg::RADIX || o_item.reg_data == redc_pkg::CODE_BLANK)))
        else $error("bad digit write");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !s_q_valid))
        else $error("output or queue not cleared by reset");

endmodule
`default_nettype wire
